// ===== design/rla_pkg.sv =====
`default_nettype none
package rla_pkg;

    localparam int MAX_REGIONS = 64;
    localparam int OFFSET_BITS = 24;
    localparam int SLOT_W      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int SIZE_W      = OFFSET_BITS + 1;

    // cell operations
    localparam logic [2:0] OP_HOLD   = 3'd0;
    localparam logic [2:0] OP_ROT    = 3'd1;
    localparam logic [2:0] OP_INIT   = 3'd2;
    localparam logic [2:0] OP_SET_A  = 3'd3;
    localparam logic [2:0] OP_INSERT = 3'd4;
    localparam logic [2:0] OP_DEL1   = 3'd5;
    localparam logic [2:0] OP_DEL2   = 3'd6;

    // request codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // register indexes
    localparam logic [1:0] REG_POOL   = 2'd0;
    localparam logic [1:0] REG_POLICY = 2'd1;

    // hole choice
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_NEXT  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_BEST  = 2'd3;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] length;
        logic                   used;
        logic [SLOT_W-1:0]      slot;
    } entry_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [SLOT_W-1:0] pos;
        entry_t            ent_a;
        entry_t            ent_b;
    } ctrl_t;

endpackage
`default_nettype wire

// ===== design/rla_cell.sv =====
`default_nettype none
module rla_cell (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [rla_pkg::SLOT_W-1:0] idx,
    input  wire rla_pkg::ctrl_t           ctrl,
    input  wire rla_pkg::entry_t          left,
    input  wire rla_pkg::entry_t          right1,
    input  wire rla_pkg::entry_t          right2,
    output rla_pkg::entry_t               q
);
    import rla_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;
    logic   at_pos;
    logic   at_pos1;
    logic   after_pos;

    assign q         = ent_reg;
    assign at_pos    = (idx == ctrl.pos);
    assign at_pos1   = ({1'b0, idx} == ({1'b0, ctrl.pos} + 1'b1));
    assign after_pos = (idx > ctrl.pos);

    always_comb begin
        ent_next = ent_reg;
        case (ctrl.op)
            OP_HOLD:   ent_next = ent_reg;
            OP_ROT:    ent_next = right1;
            OP_INIT:   if (idx == '0) ent_next = ctrl.ent_a;
            OP_SET_A:  if (at_pos) ent_next = ctrl.ent_a;
            OP_INSERT: begin
                if (at_pos)         ent_next = ctrl.ent_a;
                else if (at_pos1)   ent_next = ctrl.ent_b;
                else if (after_pos) ent_next = left;
            end
            OP_DEL1: begin
                if (at_pos)         ent_next = ctrl.ent_a;
                else if (after_pos) ent_next = right1;
            end
            OP_DEL2: begin
                if (at_pos)         ent_next = ctrl.ent_a;
                else if (after_pos) ent_next = right2;
            end
            default:   ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg <= '0;
        end else begin
            ent_reg <= ent_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/region_list_allocator_top.sv =====
`default_nettype none
// channel   valid     ready     payload
// s_        s_valid   s_ready   s_command, s_request_size, s_free_offset
// m_        m_valid   m_ready   m_offset, m_ok, m_region_count
// cfg_      cfg_wr_en -         cfg_index, cfg_data
//
// each transaction is accepted, then the cell chain makes one full rotation (one cell per
// cycle past the head), then the chosen entry is set, split or merged, then the result is
// loaded into the output register
// reset (synchronous, aresetn low) leaves one zero-length hole in slot zero
// a new transaction is taken once the previous one has left the sequencer; a stalled
// result waits in the output register while the next transaction is accepted
module region_list_allocator_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_command,
    input  wire logic [rla_pkg::OFFSET_BITS-1:0] s_request_size,
    input  wire logic [rla_pkg::OFFSET_BITS-1:0] s_free_offset,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [rla_pkg::OFFSET_BITS-1:0]      m_offset,
    output logic                                 m_ok,
    output logic [rla_pkg::CNT_W-1:0]            m_region_count,
    input  wire logic                            cfg_wr_en,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [rla_pkg::OFFSET_BITS-1:0] cfg_data
);
    import rla_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_ACT  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [CNT_W-1:0]  NONE_SLOT = CNT_W'(MAX_REGIONS);
    localparam logic [SIZE_W-1:0] POOL_MAX  = {1'b0, {(OFFSET_BITS-2){1'b1}}, 2'b00};

    // the cell chain
    ctrl_t  ctrl;
    entry_t cell_q [MAX_REGIONS];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_REGIONS; gi++) begin : g_cell
            entry_t l_in, r1_in, r2_in;
            if (gi == 0) begin : g_l0
                assign l_in = '0;
            end else begin : g_l
                assign l_in = cell_q[gi-1];
            end
            // the last cell closes the ring for rotation
            if (gi == MAX_REGIONS - 1) begin : g_r1w
                assign r1_in = cell_q[0];
            end else begin : g_r1
                assign r1_in = cell_q[gi+1];
            end
            if (gi + 2 < MAX_REGIONS) begin : g_r2
                assign r2_in = cell_q[gi+2];
            end else begin : g_r2z
                assign r2_in = '0;
            end
            rla_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .idx     (SLOT_W'(gi)),
                .ctrl    (ctrl),
                .left    (l_in),
                .right1  (r1_in),
                .right2  (r2_in),
                .q       (cell_q[gi])
            );
        end
    endgenerate

    // control and list bookkeeping
    logic [1:0]             state_reg;
    logic [1:0]             policy_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       rover_reg;
    logic [MAX_REGIONS-1:0] taken_reg;

    // transaction being worked on
    logic                   cmd_reg;
    logic [SIZE_W-1:0]      size_reg;
    logic [OFFSET_BITS-1:0] where_reg;
    logic [SLOT_W-1:0]      k_reg;

    // scan results
    logic   found_reg;
    logic [SLOT_W-1:0] hp_reg;
    entry_t h_reg;
    logic   seen_rov_reg;
    logic   fa_found_reg;
    logic [SLOT_W-1:0] fa_pos_reg;
    entry_t fa_reg;
    entry_t prev_reg;
    logic   hit_prev_ok_reg;
    entry_t hit_prev_reg;
    logic   next_ok_reg;
    entry_t next_reg;

    // staged result
    logic [OFFSET_BITS-1:0] res_ofs_reg;
    logic                   res_ok_reg;

    entry_t            cur;
    logic              valid_k;
    logic              fit_cur;
    logic              rov_here;
    logic              seen_now;
    logic [SIZE_W-1:0] rnd_size;
    logic [SIZE_W-1:0] pool_val;
    logic [SLOT_W-1:0] free_slot;
    logic              out_free;

    // choice made at the end of the scan
    logic              sel_found;
    logic [SLOT_W-1:0] sel_pos;
    entry_t            sel;

    assign cur      = cell_q[0];
    assign valid_k  = (CNT_W'(k_reg) < cnt_reg);
    assign fit_cur  = !cur.used && ({1'b0, cur.length} >= size_reg);
    assign rov_here = valid_k && (rover_reg == CNT_W'(cur.slot));
    assign seen_now = seen_rov_reg || rov_here;
    assign rnd_size = ({1'b0, s_request_size} + SIZE_W'(3)) & ~SIZE_W'(3);
    assign out_free = !m_valid || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        pool_val = ({1'b0, cfg_data} + SIZE_W'(3)) & ~SIZE_W'(3);
        if (pool_val > POOL_MAX) pool_val = POOL_MAX;
    end

    // lowest slot not in use
    always_comb begin
        free_slot = '0;
        for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
            if (!taken_reg[i]) free_slot = SLOT_W'(i);
        end
    end

    always_comb begin
        if (policy_reg == FIT_NEXT && fa_found_reg) begin
            sel_found = 1'b1;
            sel_pos   = fa_pos_reg;
            sel       = fa_reg;
        end else begin
            sel_found = found_reg;
            sel_pos   = hp_reg;
            sel       = h_reg;
        end
    end

    // free-side merge decisions
    logic merge_prev;
    logic merge_next;
    assign merge_prev = hit_prev_ok_reg && !hit_prev_reg.used;
    assign merge_next = next_ok_reg && !next_reg.used;

    logic [SLOT_W-1:0] hp_less1;
    assign hp_less1 = hp_reg - 1'b1;

    // cell control
    always_comb begin
        ctrl = '0;
        ctrl.op = OP_HOLD;
        if (cfg_wr_en && cfg_index == REG_POOL) begin
            ctrl.op           = OP_INIT;
            ctrl.ent_a.length = pool_val[OFFSET_BITS-1:0];
        end else if (state_reg == ST_SCAN) begin
            ctrl.op = OP_ROT;
        end else if (state_reg == ST_ACT) begin
            if (cmd_reg == CMD_ALLOC) begin
                if (sel_found) begin
                    if ({1'b0, sel.length} == size_reg) begin
                        ctrl.op         = OP_SET_A;
                        ctrl.pos        = sel_pos;
                        ctrl.ent_a      = sel;
                        ctrl.ent_a.used = 1'b1;
                    end else if (cnt_reg != NONE_SLOT) begin
                        // split: used front, hole keeps the rest
                        ctrl.op           = OP_INSERT;
                        ctrl.pos          = sel_pos;
                        ctrl.ent_a.start  = sel.start;
                        ctrl.ent_a.length = size_reg[OFFSET_BITS-1:0];
                        ctrl.ent_a.used   = 1'b1;
                        ctrl.ent_a.slot   = free_slot;
                        ctrl.ent_b.start  = sel.start + size_reg[OFFSET_BITS-1:0];
                        ctrl.ent_b.length = sel.length - size_reg[OFFSET_BITS-1:0];
                        ctrl.ent_b.used   = 1'b0;
                        ctrl.ent_b.slot   = sel.slot;
                    end
                end
            end else if (found_reg) begin
                if (merge_prev && merge_next) begin
                    ctrl.op           = OP_DEL2;
                    ctrl.pos          = hp_less1;
                    ctrl.ent_a        = hit_prev_reg;
                    ctrl.ent_a.length = hit_prev_reg.length + h_reg.length + next_reg.length;
                end else if (merge_prev) begin
                    ctrl.op           = OP_DEL1;
                    ctrl.pos          = hp_less1;
                    ctrl.ent_a        = hit_prev_reg;
                    ctrl.ent_a.length = hit_prev_reg.length + h_reg.length;
                end else if (merge_next) begin
                    ctrl.op           = OP_DEL1;
                    ctrl.pos          = hp_reg;
                    ctrl.ent_a        = h_reg;
                    ctrl.ent_a.used   = 1'b0;
                    ctrl.ent_a.length = h_reg.length + next_reg.length;
                end else begin
                    ctrl.op         = OP_SET_A;
                    ctrl.pos        = hp_reg;
                    ctrl.ent_a      = h_reg;
                    ctrl.ent_a.used = 1'b0;
                end
            end
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            policy_reg <= FIT_FIRST;
            cnt_reg    <= CNT_W'(1);
            rover_reg  <= '0;
            taken_reg  <= MAX_REGIONS'(1);
            m_valid    <= 1'b0;
        end else begin
            // output register: loaded when free, else emptied by the receiver
            if (state_reg == ST_DONE && out_free) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_POOL: begin
                        cnt_reg   <= CNT_W'(1);
                        rover_reg <= '0;
                        taken_reg <= MAX_REGIONS'(1);
                    end
                    REG_POLICY: policy_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg      <= s_command;
                        size_reg     <= rnd_size;
                        where_reg    <= s_free_offset;
                        k_reg        <= '0;
                        found_reg    <= 1'b0;
                        fa_found_reg <= 1'b0;
                        seen_rov_reg <= 1'b0;
                        next_ok_reg  <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    prev_reg     <= cur;
                    seen_rov_reg <= seen_now;
                    if (cmd_reg == CMD_ALLOC) begin
                        if (valid_k && fit_cur) begin
                            case (policy_reg)
                                FIT_FIRST, FIT_NEXT: begin
                                    if (!found_reg) begin
                                        found_reg <= 1'b1;
                                        hp_reg    <= k_reg;
                                        h_reg     <= cur;
                                    end
                                end
                                FIT_WORST: begin
                                    if (!found_reg || cur.length > h_reg.length) begin
                                        found_reg <= 1'b1;
                                        hp_reg    <= k_reg;
                                        h_reg     <= cur;
                                    end
                                end
                                FIT_BEST: begin
                                    if (!found_reg || cur.length < h_reg.length) begin
                                        found_reg <= 1'b1;
                                        hp_reg    <= k_reg;
                                        h_reg     <= cur;
                                    end
                                end
                                default: ;
                            endcase
                            // next fit: first hole from the rover onwards
                            if (policy_reg == FIT_NEXT && seen_now && !fa_found_reg) begin
                                fa_found_reg <= 1'b1;
                                fa_pos_reg   <= k_reg;
                                fa_reg       <= cur;
                            end
                        end
                    end else begin
                        if (valid_k && !found_reg && cur.start == where_reg) begin
                            found_reg       <= 1'b1;
                            hp_reg          <= k_reg;
                            h_reg           <= cur;
                            hit_prev_ok_reg <= (k_reg != '0);
                            hit_prev_reg    <= prev_reg;
                        end
                        if (valid_k && found_reg &&
                            ({1'b0, k_reg} == ({1'b0, hp_reg} + 1'b1))) begin
                            next_ok_reg <= 1'b1;
                            next_reg    <= cur;
                        end
                    end
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == SLOT_W'(MAX_REGIONS - 1)) state_reg <= ST_ACT;
                end
                ST_ACT: begin
                    res_ok_reg  <= 1'b0;
                    res_ofs_reg <= '0;
                    if (cmd_reg == CMD_ALLOC) begin
                        if (policy_reg == FIT_NEXT) begin
                            rover_reg <= sel_found ? CNT_W'(sel.slot) : NONE_SLOT;
                        end
                        if (sel_found) begin
                            if ({1'b0, sel.length} == size_reg) begin
                                res_ok_reg  <= 1'b1;
                                res_ofs_reg <= sel.start;
                            end else if (cnt_reg != NONE_SLOT) begin
                                res_ok_reg           <= 1'b1;
                                res_ofs_reg          <= sel.start;
                                taken_reg[free_slot] <= 1'b1;
                                cnt_reg              <= cnt_reg + 1'b1;
                            end
                        end
                    end else if (found_reg) begin
                        res_ok_reg <= 1'b1;
                        if (merge_prev && merge_next) begin
                            taken_reg <= taken_reg & ~((MAX_REGIONS'(1) << h_reg.slot) |
                                                       (MAX_REGIONS'(1) << next_reg.slot));
                            cnt_reg   <= cnt_reg - CNT_W'(2);
                        end else if (merge_prev) begin
                            taken_reg[h_reg.slot] <= 1'b0;
                            cnt_reg               <= cnt_reg - 1'b1;
                        end else if (merge_next) begin
                            taken_reg[next_reg.slot] <= 1'b0;
                            cnt_reg                  <= cnt_reg - 1'b1;
                        end
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_offset       <= res_ofs_reg;
                        m_ok           <= res_ok_reg;
                        m_region_count <= cnt_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
